>>> src/qcus_pkg.sv
// Shared types, codes and constants of the quadrature count unwrap and speed unit.
package qcus_pkg;

  // Default geometry of the encoder counter and the quadrature edge factor.
  localparam int COUNTER_BITS_DEF = 16;
  localparam int QUAD_FACTOR_DEF  = 4;

  // Fixed field widths.
  localparam int OP_W   = 2;
  localparam int PPR_W  = 16;
  localparam int INTV_W = 20;
  localparam int SPD_W  = 32;
  localparam int TOT_W  = 32;

  localparam logic [PPR_W-1:0] PPR_RESET = 16'd1024;

  // Speed scaling: microseconds per second and Q16.16 fraction bits.
  localparam logic [19:0] MICRO     = 20'd1000000;
  localparam int          FRAC_BITS = 16;

  // Quotient bits produced by the divider; one more than the speed width so
  // that the negative limit can be told apart from a clamp.
  localparam int QUO_W    = SPD_W + 1;
  localparam int HI_SHIFT = QUO_W - FRAC_BITS;

  // Largest scaled count that still fits a 64-bit numerator after the
  // fraction shift; anything above saturates.
  localparam logic [63:0] NUM_GUARD = 64'h0000_FFFF_FFFF_FFFF;

  localparam logic [SPD_W-1:0] SPEED_MAX = 32'h7FFF_FFFF;
  localparam logic [SPD_W-1:0] SPEED_MIN = 32'h8000_0000;

  typedef enum logic [OP_W-1:0] {
    OP_TOTAL = 2'd0,
    OP_SPEED = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  // Status of the shared divide unit toward the sequencer.
  typedef struct packed {
    logic done;
    logic ovf;
  } div_stat_t;

endpackage

>>> src/qcus_div.sv
// Shared restoring divide unit: one compare-and-subtract per cycle.
module qcus_div #(
  parameter int DEN_W = 38,
  parameter int QUO_W = qcus_pkg::QUO_W
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [DEN_W:0]      rem_init,
  input  logic [QUO_W-1:0]    num_lo,
  input  logic [DEN_W-1:0]    den,
  output qcus_pkg::div_stat_t stat,
  output logic [QUO_W-1:0]    quo
);
  import qcus_pkg::*;

  localparam int REM_W = DEN_W + 1;
  localparam int CNT_W = $clog2(QUO_W);

  logic [REM_W-1:0] rem_r, rem_nxt;
  logic [QUO_W-1:0] quo_r, quo_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             chk_r, chk_nxt;
  logic             done_r, done_nxt;
  logic             ovf_r, ovf_nxt;

  logic [REM_W-1:0] trial;
  logic [REM_W:0]   diff;
  logic             ge;

  // The one subtractor: the first pass checks the high part for overflow,
  // later passes shift in one numerator bit each.
  always_comb begin
    trial = chk_r ? rem_r : {rem_r[REM_W-2:0], quo_r[QUO_W-1]};
    diff  = {1'b0, trial} - {2'b00, den};
    ge    = ~diff[REM_W];
  end

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    chk_nxt  = chk_r;
    ovf_nxt  = ovf_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = rem_init;
      quo_nxt  = num_lo;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
      chk_nxt  = 1'b1;
      ovf_nxt  = 1'b0;
    end else if (busy_r) begin
      if (chk_r) begin
        chk_nxt = 1'b0;
        if (ge) begin
          // quotient would not fit: stop early
          ovf_nxt  = 1'b1;
          busy_nxt = 1'b0;
          done_nxt = 1'b1;
        end
      end else begin
        rem_nxt = ge ? diff[REM_W-1:0] : trial;
        quo_nxt = {quo_r[QUO_W-2:0], ge};
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(QUO_W - 1)) begin
          busy_nxt = 1'b0;
          done_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      chk_r  <= 1'b0;
      done_r <= 1'b0;
      ovf_r  <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      chk_r  <= chk_nxt;
      done_r <= done_nxt;
      ovf_r  <= ovf_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
  end

  assign stat.done = done_r;
  assign stat.ovf  = ovf_r;
  assign quo       = quo_r;

endmodule

>>> src/quadrature_count_unwrap_speed_unit.sv
// Top level: quadrature counter unwrap, position total and speed estimate.
//
//   channel   direction  handshake              payload
//   in_       input      in_valid / in_ready    in_op, in_counter_value, in_interval_us
//   out_      output     out_valid / out_ready  out_signed_count, out_count_delta,
//                                               out_total_count, out_speed_q16,
//                                               out_speed_saturated
//   cfg_      input      cfg_we (no wait)       cfg_wdata = pulses per revolution
//
// Total-only and clear transactions go from ST_IDLE to ST_EMIT, which loads the
// output register once it is free. A speed transaction goes through ST_MUL,
// ST_LOAD, ST_DIV and ST_EMIT; in ST_DIV the shared divide unit makes an overflow
// check pass, then produces one quotient bit per cycle over 33 bits. A zero
// interval, zero pulses per revolution or a numerator above the guard skips the
// divide and goes from ST_LOAD straight to ST_EMIT.
// in_ready is high only while the sequencer idles.
// A stalled result sits in the output register; the next transaction is taken
// meanwhile and waits for that register to drain before it is presented.
// Reset (rst_n low at a clock edge) clears the tracker state, pulses per
// revolution returns to 1024, and no result is pending.
module quadrature_count_unwrap_speed_unit #(
  parameter int COUNTER_BITS = qcus_pkg::COUNTER_BITS_DEF,
  parameter int QUAD_FACTOR  = qcus_pkg::QUAD_FACTOR_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [qcus_pkg::PPR_W-1:0]       cfg_wdata,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [qcus_pkg::OP_W-1:0]        in_op,
  input  logic [COUNTER_BITS-1:0]          in_counter_value,
  input  logic [qcus_pkg::INTV_W-1:0]      in_interval_us,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [COUNTER_BITS-1:0]   out_signed_count,
  output logic signed [COUNTER_BITS:0]     out_count_delta,
  output logic signed [qcus_pkg::TOT_W-1:0] out_total_count,
  output logic signed [qcus_pkg::SPD_W-1:0] out_speed_q16,
  output logic                             out_speed_saturated
);
  import qcus_pkg::*;

  localparam int CB    = COUNTER_BITS;
  localparam int QF_W  = $clog2(QUAD_FACTOR + 1);
  localparam int DEN_W = INTV_W + PPR_W + QF_W;
  // Scaled count: magnitude times one million.
  localparam int PW    = CB + 20;

  // Unwrap limits in the delta's own width.
  localparam logic signed [CB:0] LIM_POS = (CB+1)'((64'd1 << (CB - 1)) - 64'd1);
  localparam logic signed [CB:0] LIM_NEG = -LIM_POS;
  localparam logic [CB:0]        MODULUS = (CB+1)'(64'd1 << CB);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_MUL  = 5'b00010,
    ST_LOAD = 5'b00100,
    ST_DIV  = 5'b01000,
    ST_EMIT = 5'b10000
  } state_t;

  state_t                   state_r, state_nxt;
  logic [PPR_W-1:0]         ppr_r, ppr_nxt;
  logic signed [CB-1:0]     last_sample_r, last_sample_nxt;
  logic [TOT_W-1:0]         total_r, total_nxt;
  logic [SPD_W-1:0]         last_speed_r, last_speed_nxt;
  logic                     sat_r, sat_nxt;
  logic signed [CB:0]       delta_r, delta_nxt;
  logic [INTV_W-1:0]        dt_r, dt_nxt;
  logic [PW-1:0]            prod_r, prod_nxt;
  logic [DEN_W-1:0]         den_r, den_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic signed [CB-1:0]     out_count_r, out_count_nxt;
  logic signed [CB:0]       out_delta_r, out_delta_nxt;
  logic [TOT_W-1:0]         out_total_r, out_total_nxt;
  logic [SPD_W-1:0]         out_speed_r, out_speed_nxt;
  logic                     out_sat_r, out_sat_nxt;

  logic signed [CB-1:0]     now;
  logic signed [CB:0]       diff_raw;
  logic signed [CB:0]       unwrapped;
  logic [CB-1:0]            mag;
  logic [INTV_W+PPR_W-1:0]  dtppr;
  logic                     num_big;
  logic                     div_start;
  div_stat_t                div_stat;
  logic [QUO_W-1:0]         div_quo;
  logic [SPD_W:0]           spd_res;

  // Apply the sign to the quotient and clamp to the Q16.16 range.
  // Result: {saturated, speed}.
  function automatic logic [SPD_W:0] sign_clamp(input logic neg, input logic ovf,
                                               input logic [QUO_W-1:0] q);
    logic             sat;
    logic [SPD_W-1:0] spd;
    if (neg) begin
      sat = ovf || (q > {1'b0, SPEED_MIN});
      spd = sat ? SPEED_MIN : SPD_W'(QUO_W'(0) - q);
    end else begin
      sat = ovf || (q > {1'b0, SPEED_MAX});
      spd = sat ? SPEED_MAX : q[SPD_W-1:0];
    end
    return {sat, spd};
  endfunction

  // Sign-extend the reading and unwrap the difference across the counter
  // rollover; adding or dropping the modulus is the same in this width.
  always_comb begin
    now       = signed'(in_counter_value);
    diff_raw  = {now[CB-1], now} - {last_sample_r[CB-1], last_sample_r};
    unwrapped = ((diff_raw > LIM_POS) || (diff_raw < LIM_NEG)) ?
                diff_raw + signed'(MODULUS) : diff_raw;
  end

  // Operands of the speed divide.
  always_comb begin
    mag     = CB'(delta_r[CB] ? -delta_r : delta_r);
    dtppr   = dt_r * ppr_r;
    num_big = 64'(prod_r) > NUM_GUARD;
    spd_res = sign_clamp(delta_r[CB], div_stat.ovf, div_quo);
  end

  qcus_div #(
    .DEN_W (DEN_W),
    .QUO_W (QUO_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .rem_init ((DEN_W+1)'(prod_r >> HI_SHIFT)),
    .num_lo   ({prod_r[HI_SHIFT-1:0], {FRAC_BITS{1'b0}}}),
    .den      (den_r),
    .stat     (div_stat),
    .quo      (div_quo)
  );

  always_comb begin
    state_nxt       = state_r;
    ppr_nxt         = ppr_r;
    last_sample_nxt = last_sample_r;
    total_nxt       = total_r;
    last_speed_nxt  = last_speed_r;
    sat_nxt         = sat_r;
    delta_nxt       = delta_r;
    dt_nxt          = dt_r;
    prod_nxt        = prod_r;
    den_nxt         = den_r;
    out_valid_nxt   = out_valid_r;
    out_count_nxt   = out_count_r;
    out_delta_nxt   = out_delta_r;
    out_total_nxt   = out_total_r;
    out_speed_nxt   = out_speed_r;
    out_sat_nxt     = out_sat_r;
    div_start       = 1'b0;

    if (cfg_we) begin
      ppr_nxt = cfg_wdata;
    end

    // Drop the presented result once it is taken.
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          unique case (op_t'(in_op))
            OP_TOTAL, OP_SPEED: begin
              last_sample_nxt = now;
              delta_nxt       = unwrapped;
              total_nxt       = total_r + TOT_W'(unwrapped);
              dt_nxt          = in_interval_us;
              sat_nxt         = 1'b0;
              state_nxt       = (op_t'(in_op) == OP_SPEED) ? ST_MUL : ST_EMIT;
            end
            OP_CLEAR: begin
              last_sample_nxt = '0;
              delta_nxt       = '0;
              total_nxt       = '0;
              last_speed_nxt  = '0;
              sat_nxt         = 1'b0;
              state_nxt       = ST_EMIT;
            end
            OP_NONE: begin
              // unused code: take it and leave the state alone
            end
            default: begin
            end
          endcase
        end
      end
      ST_MUL: begin
        prod_nxt  = PW'(mag) * PW'(MICRO);
        den_nxt   = DEN_W'(dtppr) * DEN_W'(QUAD_FACTOR);
        state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        if (den_r == '0) begin
          last_speed_nxt = '0;
          state_nxt      = ST_EMIT;
        end else if (num_big) begin
          // numerator beyond 64 bits: clamp without dividing
          last_speed_nxt = delta_r[CB] ? SPEED_MIN : SPEED_MAX;
          sat_nxt        = 1'b1;
          state_nxt      = ST_EMIT;
        end else begin
          div_start = 1'b1;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_stat.done) begin
          last_speed_nxt = spd_res[SPD_W-1:0];
          sat_nxt        = spd_res[SPD_W];
          state_nxt      = ST_EMIT;
        end
      end
      ST_EMIT: begin
        // Hold until the output register is free, then advance.
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_count_nxt = last_sample_r;
          out_delta_nxt = delta_r;
          out_total_nxt = total_r;
          out_speed_nxt = last_speed_r;
          out_sat_nxt   = sat_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      ppr_r         <= PPR_RESET;
      last_sample_r <= '0;
      total_r       <= '0;
      last_speed_r  <= '0;
      sat_r         <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      ppr_r         <= ppr_nxt;
      last_sample_r <= last_sample_nxt;
      total_r       <= total_nxt;
      last_speed_r  <= last_speed_nxt;
      sat_r         <= sat_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    delta_r     <= delta_nxt;
    dt_r        <= dt_nxt;
    prod_r      <= prod_nxt;
    den_r       <= den_nxt;
    out_count_r <= out_count_nxt;
    out_delta_r <= out_delta_nxt;
    out_total_r <= out_total_nxt;
    out_speed_r <= out_speed_nxt;
    out_sat_r   <= out_sat_nxt;
  end

  assign in_ready            = (state_r == ST_IDLE);
  assign out_valid           = out_valid_r;
  assign out_signed_count    = out_count_r;
  assign out_count_delta     = out_delta_r;
  assign out_total_count     = signed'(out_total_r);
  assign out_speed_q16       = signed'(out_speed_r);
  assign out_speed_saturated = out_sat_r;

endmodule

>>> src/qcus_chk.sv
// Port-level checker for the quadrature count unwrap and speed unit, with its bind.
module qcus_chk #(
  parameter int COUNTER_BITS = qcus_pkg::COUNTER_BITS_DEF
) (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic [qcus_pkg::OP_W-1:0]         in_op,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic signed [COUNTER_BITS-1:0]    out_signed_count,
  input logic signed [COUNTER_BITS:0]      out_count_delta,
  input logic signed [qcus_pkg::TOT_W-1:0] out_total_count,
  input logic signed [qcus_pkg::SPD_W-1:0] out_speed_q16,
  input logic                              out_speed_saturated
);
  import qcus_pkg::*;

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_signed_count) &&
      $stable(out_count_delta) && $stable(out_total_count) &&
      $stable(out_speed_q16) && $stable(out_speed_saturated))
    else $error("result changed while stalled");

  // An unused op is dropped and the input side is free again at once.
  a_none_drop: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_op == OP_NONE) |=> in_ready)
    else $error("unused op did not return to ready");

  // A speed transaction occupies the divide sequence.
  a_speed_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_op == OP_SPEED) |=> !in_ready)
    else $error("ready during speed computation");

  // A clamp shows one of the two range ends and needs a nonzero delta.
  a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_speed_saturated |->
      (out_count_delta != '0) &&
      ((out_speed_q16 == SPEED_MAX) || (out_speed_q16 == SPEED_MIN)))
    else $error("saturated speed off the range ends");

endmodule

bind quadrature_count_unwrap_speed_unit qcus_chk #(
  .COUNTER_BITS (COUNTER_BITS)
) u_qcus_chk (.*);

>>> tb/sv/tb_quadrature_count_unwrap_speed_unit.sv
// Self-checking testbench of the quadrature count unwrap and speed unit.
module tb_quadrature_count_unwrap_speed_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import qcus_pkg::*;

  localparam int CNT_W          = COUNTER_BITS_DEF;
  localparam int QUAD           = QUAD_FACTOR_DEF;
  localparam longint SPAN       = longint'(1) << CNT_W;
  localparam longint HALF_SPAN  = SPAN / 2 - 1;
  localparam longint US_PER_S   = 1000000;
  // Scaled count above this would overflow 64 bits once shifted by the fraction.
  localparam logic [63:0] SHIFT_GUARD = 64'h0000_FFFF_FFFF_FFFF;
  // Cycles of no transaction at all before the run is declared hung.
  localparam int WATCHDOG_LIMIT = 5000;
  // Longest internal work (a speed divide) plus margin; covers ignored ops.
  localparam int SETTLE_CYCLES  = 60;

  typedef struct packed {
    logic signed [CNT_W-1:0] signed_count;
    logic signed [CNT_W:0]   count_delta;
    logic signed [TOT_W-1:0] total_count;
    logic signed [SPD_W-1:0] speed_q16;
    logic                    speed_saturated;
  } quad_result_t;

  logic                     clk;
  logic                     rst_n;
  logic                     cfg_we;
  logic [PPR_W-1:0]         cfg_wdata;
  logic                     in_valid;
  logic                     in_ready;
  logic [OP_W-1:0]          in_op;
  logic [CNT_W-1:0]         in_counter_value;
  logic [INTV_W-1:0]        in_interval_us;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic signed [CNT_W-1:0]  out_signed_count;
  logic signed [CNT_W:0]    out_count_delta;
  logic signed [TOT_W-1:0]  out_total_count;
  logic signed [SPD_W-1:0]  out_speed_q16;
  logic                     out_speed_saturated;

  // Tracker copy kept by the testbench, updated at each accepted transaction.
  logic signed [CNT_W-1:0]  trk_last;
  logic [TOT_W-1:0]         trk_total;
  logic [SPD_W-1:0]         trk_speed;
  logic [PPR_W-1:0]         trk_ppr;
  quad_result_t             pending_readings[$];

  // Stimulus-side encoder position, walked in steps to make realistic readings.
  logic [CNT_W-1:0]         enc_pos;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_request   = 0;
  int hold_left      = 0;
  int stall_cycles   = 0;
  int error_count    = 0;
  int n_sent         = 0;
  int n_results      = 0;
  int n_sat          = 0;
  int n_clear        = 0;
  int n_ignored      = 0;
  int n_ppr_writes   = 0;

  quadrature_count_unwrap_speed_unit uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_wdata           (cfg_wdata),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_op               (in_op),
    .in_counter_value    (in_counter_value),
    .in_interval_us      (in_interval_us),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_signed_count    (out_signed_count),
    .out_count_delta     (out_count_delta),
    .out_total_count     (out_total_count),
    .out_speed_q16       (out_speed_q16),
    .out_speed_saturated (out_speed_saturated)
  );

  // 2 ns clock: low half, then high half.
  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Speed in Q16.16 rev/s from an unwrapped delta; clamp to the signed 32-bit range.
  function automatic logic [SPD_W-1:0] speed_estimate(input longint delta,
                                                      input logic [INTV_W-1:0] dt,
                                                      input logic [PPR_W-1:0] ppr,
                                                      output logic clamped);
    logic [63:0] den;
    logic [63:0] mag;
    logic [63:0] num;
    logic [63:0] quo;
    clamped = 1'b0;
    den = 64'(dt) * 64'(ppr) * 64'(QUAD);
    // Zero interval or zero pulses per rev: speed is simply zero.
    if (den == 64'd0) return '0;
    mag = (delta < 0) ? 64'(-delta) : 64'(delta);
    num = mag * 64'(US_PER_S);
    if (num > SHIFT_GUARD) quo = '1;
    else quo = (num << FRAC_BITS) / den;
    if (delta < 0) begin
      // The negative limit itself is reachable without a clamp.
      if (quo > 64'h8000_0000) begin
        clamped = 1'b1;
        return SPEED_MIN;
      end
      return 32'(64'd0 - quo);
    end
    if (quo > 64'h7FFF_FFFF) begin
      clamped = 1'b1;
      return SPEED_MAX;
    end
    return 32'(quo);
  endfunction

  // Apply one accepted transaction to the tracker copy and queue its reading.
  task automatic advance_tracker(input op_t op, input logic [CNT_W-1:0] raw,
                                 input logic [INTV_W-1:0] dt);
    quad_result_t r;
    longint now_v;
    longint d;
    logic clamped;
    r = '0;
    clamped = 1'b0;
    if (op == OP_NONE) begin
      // Unused code: no reading, no state change.
      n_ignored++;
    end else if (op == OP_CLEAR) begin
      trk_last  = '0;
      trk_total = '0;
      trk_speed = '0;
      n_clear++;
      pending_readings.push_back(r);
    end else begin
      now_v = longint'($signed(raw));
      d = now_v - longint'(trk_last);
      // Unwrap across the counter rollover.
      if (d > HALF_SPAN) d = d - SPAN;
      else if (d < -HALF_SPAN) d = d + SPAN;
      trk_total = trk_total + 32'(d);
      trk_last  = raw;
      // A total-only sample reports the held speed, never a clamp.
      if (op == OP_SPEED) trk_speed = speed_estimate(d, dt, trk_ppr, clamped);
      if (clamped) n_sat++;
      r.signed_count    = raw;
      r.count_delta     = 17'(d);
      r.total_count     = trk_total;
      r.speed_q16       = trk_speed;
      r.speed_saturated = clamped;
      pending_readings.push_back(r);
    end
  endtask

  // Offer one transaction; entered and left at a falling edge, valid left high.
  task automatic send_item(input op_t op, input logic [CNT_W-1:0] raw,
                           input logic [INTV_W-1:0] dt);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid         <= 1'b1;
    in_op            <= op;
    in_counter_value <= raw;
    in_interval_us   <= dt;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    advance_tracker(op, raw, dt);
    n_sent++;
    @(negedge clk);
  endtask

  // Drop valid and wait until every reading has arrived and the block has settled.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_readings.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Write pulses per rev while the block is idle.
  task automatic write_ppr(input logic [PPR_W-1:0] value);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    trk_ppr = value;
    n_ppr_writes++;
  endtask

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (got !== want) begin
      if (error_count < 40)
        $display("%0t: %s mismatch, expected %0d (0x%08h), actual %0d (0x%08h)",
                 $time, name, $signed(want), want, $signed(got), got);
      error_count++;
    end
  endtask

  // Directed: rollover in both directions, clamps, zero interval, held speed,
  // clear with nonzero fields, ignored code, truncation to a tiny speed.
  task automatic test_default_ppr_edges();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_item(OP_SPEED, 16'h0000, 20'd0);
    send_item(OP_SPEED, 16'h7FFF, 20'd1);
    send_item(OP_TOTAL, 16'h8000, 20'd5);
    send_item(OP_SPEED, 16'h0000, 20'hFFFFF);
    send_item(OP_SPEED, 16'h8000, 20'd0);
    send_item(OP_SPEED, 16'h0000, 20'd1);
    send_item(OP_TOTAL, 16'hFFFF, 20'hFFFFF);
    send_item(OP_NONE,  16'h5A5A, 20'hA5A5A);
    send_item(OP_CLEAR, 16'hFFFF, 20'hFFFFF);
    send_item(OP_TOTAL, 16'h1234, 20'd0);
    send_item(OP_SPEED, 16'h1235, 20'hFFFFF);
  endtask

  // Directed: register extremes, the exact negative limit without a clamp,
  // the positive limit with one, and zero pulses per rev.
  task automatic test_ppr_extremes();
    write_ppr(16'd1);
    send_item(OP_CLEAR, 16'h0000, 20'd0);
    send_item(OP_SPEED, 16'h0800, 20'd15625);
    send_item(OP_SPEED, 16'h0000, 20'd15625);
    send_item(OP_SPEED, 16'h8000, 20'd1);
    send_item(OP_SPEED, 16'h0000, 20'd1);
    write_ppr(16'hFFFF);
    send_item(OP_SPEED, 16'h7FFF, 20'hFFFFF);
    send_item(OP_TOTAL, 16'hC000, 20'd3);
    write_ppr(16'h0000);
    send_item(OP_SPEED, 16'h4000, 20'd1);
    send_item(OP_NONE,  16'hA5A5, 20'h5A5A5);
    write_ppr(PPR_RESET);
    send_item(OP_SPEED, 16'h0001, 20'd250);
  endtask

  // Random readings: mostly small encoder steps, some large ones and rollover
  // boundaries, occasional clears and unused codes; mixed intervals.
  task automatic random_samples(input int count);
    int done_cnt;
    int pick;
    int step;
    op_t op;
    logic [INTV_W-1:0] dt;
    done_cnt = 0;
    while (done_cnt < count) begin
      pick = $urandom_range(99);
      if (pick < 3) op = OP_NONE;
      else if (pick < 7) op = OP_CLEAR;
      else if (pick < 37) op = OP_TOTAL;
      else op = OP_SPEED;
      pick = $urandom_range(99);
      step = 0;
      if (pick < 55) step = int'($urandom_range(400)) - 200;
      else if (pick < 75) step = int'($urandom_range(65535)) - 32768;
      else if (pick < 85) begin
        case ($urandom_range(3))
          0: step = 32767;
          1: step = -32767;
          2: step = 32768;
          default: step = -32768;
        endcase
      end else enc_pos = 16'($urandom);
      enc_pos = enc_pos + 16'(step);
      pick = $urandom_range(99);
      if (pick < 10) dt = '0;
      else if (pick < 50) dt = 20'($urandom_range(1, 2000));
      else if (pick < 75) dt = 20'($urandom_range(1, 100000));
      else dt = 20'($urandom_range(0, 20'hFFFFF));
      if (op == OP_NONE) send_item(op, 16'($urandom), 20'($urandom));
      else send_item(op, enc_pos, dt);
      // The block restarts from zero after a clear; follow it.
      if (op == OP_CLEAR) enc_pos = '0;
      if (op != OP_NONE) done_cnt++;
    end
  endtask

  // Four idle mixes, each under a fresh pulses-per-rev setting.
  task automatic test_random_traffic();
    int phase;
    for (phase = 0; phase < 4; phase++) begin
      if ($urandom_range(1)) write_ppr(16'($urandom_range(1, 16)));
      else write_ppr(16'($urandom_range(1, 65535)));
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 52; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 52; end
        default: begin send_idle_pct = 9; recv_stall_pct = 9; end
      endcase
      random_samples(250);
    end
  endtask

  // Hold the receiver off for a long stretch while the sender keeps offering,
  // so the output register fills and in_ready drops.
  task automatic test_output_backpressure();
    write_ppr(16'd4096);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_request   = 400;
    random_samples(30);
  endtask

  // Receiver: random stalls, plus the long hold-off counted down here.
  always @(negedge clk) begin
    if (hold_request != 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Check each delivered reading against the oldest one predicted.
  always @(posedge clk) begin
    quad_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_readings.size() == 0) begin
        if (error_count < 40)
          $display("%0t: extra reading, expected none, actual %0d %0d %0d 0x%08h %0d",
                   $time, out_signed_count, out_count_delta, out_total_count,
                   out_speed_q16, out_speed_saturated);
        error_count++;
      end else begin
        want = pending_readings.pop_front();
        compare_field("signed_count", 32'(want.signed_count), 32'(out_signed_count));
        compare_field("count_delta", 32'(want.count_delta), 32'(out_count_delta));
        compare_field("total_count", 32'(want.total_count), 32'(out_total_count));
        compare_field("speed_q16", 32'(want.speed_q16), 32'(out_speed_q16));
        compare_field("speed_saturated", 32'(want.speed_saturated),
                      32'(out_speed_saturated));
        n_results++;
      end
    end
  end

  // Watchdog: end the run if no transaction moves on either channel for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transaction for %0d cycles, %0d readings outstanding",
               $time, stall_cycles, pending_readings.size());
      $display("** quadrature_count_unwrap_speed_unit: FAILED **");
      $finish;
    end
  end

  initial begin
    // Drive every input to a known value before the first edge.
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_wdata        = PPR_RESET;
    in_valid         = 1'b0;
    in_op            = OP_TOTAL;
    in_counter_value = '0;
    in_interval_us   = '0;
    trk_last         = '0;
    trk_total        = '0;
    trk_speed        = '0;
    trk_ppr          = PPR_RESET;
    enc_pos          = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_default_ppr_edges();
    test_ppr_extremes();
    test_random_traffic();
    test_output_backpressure();
    drain_results();

    $display("Ran %0d transactions: %0d readings checked, %0d clamped speeds,",
             n_sent, n_results, n_sat);
    $display("%0d clears, %0d ignored codes, %0d register writes, 4 idle mixes, 1 hold-off",
             n_clear, n_ignored, n_ppr_writes);
    if (error_count == 0) begin
      $display("** quadrature_count_unwrap_speed_unit: PASSED **");
    end else begin
      $display("%0d mismatches found", error_count);
      $display("** quadrature_count_unwrap_speed_unit: FAILED **");
    end
    $finish;
  end

endmodule

>>> quadrature_count_unwrap_speed_unit.f
src/qcus_pkg.sv
src/qcus_div.sv
src/quadrature_count_unwrap_speed_unit.sv
src/qcus_chk.sv
tb/sv/tb_quadrature_count_unwrap_speed_unit.sv
